// ----- hdl/pwr_pkg.sv -----
// Shared constants and the report frame table for the presence window reporter.
`default_nettype none
package pwr_pkg;

   localparam int CNT_W = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int BYTE_W = 8;
   localparam int FRAME_LEN = 8;
   localparam int IDX_W = $clog2(FRAME_LEN);

   localparam logic [CNT_W-1:0] WIN_EMPTY_RESET = CNT_W'(10);
   localparam logic [CNT_W-1:0] WIN_OCC_RESET = CNT_W'(150);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

   typedef enum logic [0:0] {
      REG_WIN_EMPTY = 1'b0,
      REG_WIN_OCC = 1'b1
   } reg_sel_type;

   localparam logic [BYTE_W-1:0] HDR_SYNC0 = 8'h5A;
   localparam logic [BYTE_W-1:0] HDR_SYNC1 = 8'hA5;
   localparam logic [BYTE_W-1:0] HDR_KIND = 8'h01;
   localparam logic [BYTE_W-1:0] HDR_PAD = 8'h00;

   function automatic logic [BYTE_W-1:0] frame_byte(input logic [IDX_W-1:0] idx,
                                                    input logic arrival);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0: b = HDR_SYNC0;
         3'd1: b = HDR_SYNC1;
         3'd2: b = HDR_KIND;
         3'd7: b = {{(BYTE_W-1){1'b0}}, arrival};
         default: b = HDR_PAD;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/presence_window_reporter_top.sv -----
// Top level of the presence window reporter: tick counting, occupancy decision and report framing.
//
//   channel  | dir | handshake              | payload
//   req      | in  | req_tvalid/req_tready  | req_tdata[0] sensor_level
//   rsp      | out | rsp_tvalid/rsp_tready  | rsp_tdata report_byte, rsp_tlast report_last
//   csr      | in  | psel/penable/pready    | window_when_empty @0x0, window_when_occupied @0x4
//
// One tick can be accepted in every cycle while req_tready is high.
// A state change at a window end starts an eight-beat frame, one beat per cycle unless stalled.
// One further frame can wait behind the one in flight; only then is req_tready low.
// The synchronous reset clears the counters, marks the area empty and loads 10 and 150.
// A stall on rsp holds the current beat and stops tick counting only once a further frame waits.
`default_nettype none
module presence_window_reporter_top (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [7:0] req_tdata,   // [0] sensor_level, [7:1] zero
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [7:0] rsp_tdata,        // [7:0] report_byte
   output logic rsp_tlast,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [pwr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [pwr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pwr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   logic [pwr_pkg::CNT_W-1:0] win_empty_ff, win_empty_in;
   logic [pwr_pkg::CNT_W-1:0] win_occ_ff, win_occ_in;
   logic [pwr_pkg::CNT_W-1:0] tick_ff, tick_in;
   logic seen_ff, seen_in;
   logic occ_ff, occ_in;
   logic active_ff, active_in;
   logic [pwr_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic pend_ff, pend_in;
   logic arrival_ff, arrival_in;
   logic pend_arr_ff, pend_arr_in;

   logic csr_write;
   pwr_pkg::reg_sel_type csr_sel;
   logic in_fire;
   logic out_fire;
   logic last_fire;
   logic [pwr_pkg::CNT_W-1:0] window;
   logic [pwr_pkg::CNT_W-1:0] tick_next;
   logic win_end;
   logic now_high;
   logic change;

   assign csr_pready = 1'b1;
   assign csr_sel = pwr_pkg::reg_sel_type'(csr_paddr[2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      win_empty_in = win_empty_ff;
      win_occ_in = win_occ_ff;
      csr_prdata = '0;
      case (csr_sel)
         pwr_pkg::REG_WIN_EMPTY: begin
            csr_prdata = {{(pwr_pkg::CSR_DATA_W-pwr_pkg::CNT_W){1'b0}}, win_empty_ff};
            if (csr_write) begin
               win_empty_in = csr_pwdata[pwr_pkg::CNT_W-1:0];
            end
         end
         pwr_pkg::REG_WIN_OCC: begin
            csr_prdata = {{(pwr_pkg::CSR_DATA_W-pwr_pkg::CNT_W){1'b0}}, win_occ_ff};
            if (csr_write) begin
               win_occ_in = csr_pwdata[pwr_pkg::CNT_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign req_tready = !pend_ff;
   assign in_fire = req_tvalid && req_tready;
   assign rsp_tvalid = active_ff;
   assign rsp_tdata = pwr_pkg::frame_byte(idx_ff, arrival_ff);
   assign rsp_tlast = (idx_ff == pwr_pkg::LAST_IDX);
   assign out_fire = active_ff && rsp_tready;
   assign last_fire = out_fire && rsp_tlast;

   assign window = occ_ff ? win_occ_ff : win_empty_ff;
   assign tick_next = tick_ff + pwr_pkg::CNT_W'(1);
   assign win_end = (tick_next == window);
   assign now_high = seen_ff || req_tdata[0];
   assign change = in_fire && win_end && (now_high != occ_ff);

   always_comb begin
      tick_in = tick_ff;
      seen_in = seen_ff;
      occ_in = occ_ff;
      if (in_fire) begin
         if (win_end) begin
            tick_in = '0;
            seen_in = 1'b0;
            occ_in = now_high;
         end else begin
            tick_in = tick_next;
            seen_in = now_high;
         end
      end
   end

   always_comb begin
      active_in = active_ff;
      idx_in = idx_ff;
      arrival_in = arrival_ff;
      pend_in = pend_ff;
      pend_arr_in = pend_arr_ff;
      if (last_fire) begin
         if (pend_ff) begin
            idx_in = '0;
            arrival_in = pend_arr_ff;
            pend_in = 1'b0;
         end else if (change) begin
            idx_in = '0;
            arrival_in = now_high;
         end else begin
            active_in = 1'b0;
         end
      end else begin
         if (out_fire) begin
            idx_in = idx_ff + pwr_pkg::IDX_W'(1);
         end
         if (change) begin
            if (active_ff) begin
               pend_in = 1'b1;
               pend_arr_in = now_high;
            end else begin
               active_in = 1'b1;
               idx_in = '0;
               arrival_in = now_high;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_empty_ff <= pwr_pkg::WIN_EMPTY_RESET;
         win_occ_ff <= pwr_pkg::WIN_OCC_RESET;
         tick_ff <= '0;
         seen_ff <= 1'b0;
         occ_ff <= 1'b0;
         active_ff <= 1'b0;
         idx_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         win_empty_ff <= win_empty_in;
         win_occ_ff <= win_occ_in;
         tick_ff <= tick_in;
         seen_ff <= seen_in;
         occ_ff <= occ_in;
         active_ff <= active_in;
         idx_ff <= idx_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      arrival_ff <= arrival_in;
      pend_arr_ff <= pend_arr_in;
   end

endmodule
`default_nettype wire

// ----- hdl/pwr_checker.sv -----
// Port-level checker for the presence window reporter, bound to the top level.
`default_nettype none
module pwr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic rsp_tlast,
   input wire logic csr_pready
);

   logic [pwr_pkg::IDX_W-1:0] beat_ff, beat_in;
   logic rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign beat_in = rsp_fire ? beat_ff + pwr_pkg::IDX_W'(1) : beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= '0;
      end else begin
         beat_ff <= beat_in;
      end
   end

   a_last_on_eighth: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_tlast == (beat_ff == pwr_pkg::LAST_IDX)))
      else $error("tlast does not fall on the eighth beat of a frame.");

   a_header_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_tlast) |-> (rsp_tdata == pwr_pkg::frame_byte(beat_ff, 1'b0)))
      else $error("Frame header byte out of sequence.");

   a_flag_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_tlast) |-> (rsp_tdata[7:1] == 7'd0))
      else $error("Final frame byte is not an arrival or departure flag.");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("Stalled result beat changed.");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("Configuration port not ready.");

endmodule

bind presence_window_reporter_top pwr_checker u_pwr_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast),
   .csr_pready(csr_pready)
);
`default_nettype wire
